// ----- rtl/ssje_pkg.sv -----
// package: op and status codes and payload types for the sorted set eliminator
`timescale 1ns / 1ps
package ssje_pkg;
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_ELIM   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_BADSTEP  = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
        logic [7:0]         step;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [2:0]         status;
        logic               last;
    } t_out_item;
endpackage

// ----- rtl/ssje_if.sv -----
// interfaces: valid/ready channels for input items and result items
`timescale 1ns / 1ps
interface ssje_in_if;
    import ssje_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ssje_out_if;
    import ssje_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/sorted_set_josephus_eliminator.sv -----
// top level: sorted set in a simple dual port memory with insert, delete and josephus elimination
//
// usage
//   i_in carries items {op, value, step}; o_out carries result items
//   {result_value, status, last}. an item is taken when valid and ready are
//   both high. insert and delete give one result; eliminate gives one result
//   per stored entry (last marks the final one) or one error result.
// operation
//   the set lives in a synchronous memory read one entry per cycle. a search
//   looks at one entry at a time (address, read, compare). an insert then
//   moves the tail up one entry at a time, a delete moves it down likewise.
//   eliminate reduces idx + k - 1 modulo the live count by repeated
//   subtraction, reads the entry and deletes it.
// reset
//   i_rst_n low clears the count, the state, the output valid and the elim
//   flag; memory contents are not cleared, entries past the count are never used.
// stall
//   the block waits with its result in the output register while o_out.ready
//   is low, and accepts a new item only after its last result is taken.
`timescale 1ns / 1ps
module sorted_set_josephus_eliminator #(
    parameter int CAPACITY = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssje_in_if.sink    i_in,
    ssje_out_if.source o_out
);
    import ssje_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_SRCH_W, S_INS_RD, S_INS_WR, S_DEL_RD, S_DEL_WR,
        S_MOD, S_ELIM_RD, S_ELIM_W, S_OUT
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_count;
    logic [AW-1:0]       r_pos;     // search index / shift index
    logic [CW-1:0]       r_idx;     // josephus index
    logic [8:0]          r_acc;     // idx + k - 1 being reduced
    logic [1:0]          r_op;
    logic signed [31:0]  r_key;
    logic [7:0]          r_step;
    logic signed [31:0]  r_carry;   // value shifting forward on insert
    logic [CW-1:0]       r_scan;    // search position (can reach count)
    t_out_item           r_out;
    logic                r_out_valid;
    logic                r_elim;

    // simple dual port store: one read and one write port
    logic signed [31:0]  r_mem [CAPACITY];
    logic signed [31:0]  r_rdata;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic signed [31:0]  wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    assign i_in.ready    = (r_state == S_IDLE) && !r_out_valid;
    assign o_out.valid   = r_out_valid;
    assign o_out.data    = r_out;

    // memory address and write select
    always_comb begin
        rd_addr = r_pos;
        wr_en   = 1'b0;
        wr_addr = r_pos;
        wr_data = r_carry;
        unique case (r_state)
            S_INS_WR: begin
                wr_en = 1'b1;
            end
            S_DEL_WR: begin
                wr_en   = 1'b1;
                wr_addr = r_pos - AW'(1);
                wr_data = r_rdata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_elim      <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid && !r_out_valid) begin
                        r_op   <= i_in.data.op;
                        r_key  <= i_in.data.value;
                        r_step <= i_in.data.step;
                        r_pos  <= '0;
                        r_scan <= '0;
                        r_elim <= 1'b0;
                        unique case (i_in.data.op) inside
                            OP_INSERT, OP_DELETE: begin
                                r_state <= S_SRCH;
                            end
                            OP_ELIM: begin
                                r_out.result_value <= i_in.data.value;
                                r_out.last         <= 1'b1;
                                if (i_in.data.step == 8'd0) begin
                                    r_out.status <= ST_BADSTEP;
                                    r_state      <= S_OUT;
                                end else if (r_count == '0) begin
                                    r_out.status <= ST_EMPTY;
                                    r_state      <= S_OUT;
                                end else begin
                                    r_elim  <= 1'b1;
                                    r_idx   <= '0;
                                    r_acc   <= 9'(i_in.data.step) - 9'd1;
                                    r_state <= S_MOD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                // lower bound search, one entry at a time through address, read and compare states
                S_SRCH: begin
                    if (r_scan == r_count) begin
                        r_out.result_value <= r_key;
                        r_out.last         <= 1'b1;
                        r_pos              <= r_scan[AW-1:0];
                        if (r_op == OP_DELETE) begin
                            r_out.status <= ST_NOTFOUND;
                            r_state      <= S_OUT;
                        end else if (r_count == CW'(CAPACITY)) begin
                            r_out.status <= ST_FULL;
                            r_state      <= S_OUT;
                        end else begin
                            r_carry <= r_key;
                            r_state <= S_INS_WR;
                        end
                    end else begin
                        r_pos   <= r_scan[AW-1:0];
                        r_state <= S_SRCH_W;
                    end
                end
                S_SRCH_W: begin
                    // read of entry r_pos issued here
                    r_state <= S_INS_RD;
                end
                S_INS_RD: begin
                    r_out.result_value <= r_key;
                    r_out.last         <= 1'b1;
                    if (r_op == OP_NONE) begin
                        // insert shift running: old entry r_pos now in r_rdata
                        r_state <= S_INS_WR;
                    end else if (r_rdata < r_key) begin
                        r_scan  <= r_scan + CW'(1);
                        r_state <= S_SRCH;
                    end else if (r_rdata == r_key) begin
                        if (r_op == OP_DELETE) begin
                            r_out.status <= ST_OK;
                            r_pos        <= r_pos + AW'(1);
                            r_scan       <= r_scan + CW'(1);
                            r_state      <= S_DEL_RD;
                        end else begin
                            r_out.status <= ST_DUP;
                            r_state      <= S_OUT;
                        end
                    end else if (r_op == OP_DELETE) begin
                        r_out.status <= ST_NOTFOUND;
                        r_state      <= S_OUT;
                    end else if (r_count == CW'(CAPACITY)) begin
                        r_out.status <= ST_FULL;
                        r_state      <= S_OUT;
                    end else begin
                        // write the key at r_pos in S_INS_WR, then carry the old entry upward
                        r_carry <= r_key;
                        r_state <= S_INS_WR;
                    end
                end
                // insert shift: write carry at r_pos while old entry sits in r_rdata
                S_INS_WR: begin
                    r_out.status <= ST_OK;
                    r_carry      <= r_rdata;
                    if (r_scan == r_count) begin
                        r_count <= r_count + CW'(1);
                        r_state <= S_OUT;
                    end else begin
                        r_scan  <= r_scan + CW'(1);
                        r_pos   <= r_pos + AW'(1);
                        r_state <= S_SRCH_W;
                        r_op    <= OP_NONE;
                    end
                end
                // delete shift: r_pos is the entry to move down
                S_DEL_RD: begin
                    if (r_scan == r_count) begin
                        r_count <= r_count - CW'(1);
                        if (r_elim) begin
                            r_out.last <= (r_count == CW'(1));
                            if (r_count == CW'(1)) r_elim <= 1'b0;
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DEL_WR;
                    end
                end
                S_DEL_WR: begin
                    // read issued in S_DEL_RD is now in r_rdata; written to r_pos-1
                    r_pos   <= r_pos + AW'(1);
                    r_scan  <= r_scan + CW'(1);
                    r_state <= S_DEL_RD;
                end
                // josephus index: (idx + k - 1) mod count by repeated subtract
                S_MOD: begin
                    if (r_acc >= 9'(r_count)) begin
                        r_acc <= r_acc - 9'(r_count);
                    end else begin
                        r_idx   <= CW'(r_acc);
                        r_pos   <= r_acc[AW-1:0];
                        r_state <= S_ELIM_RD;
                    end
                end
                S_ELIM_RD: begin
                    r_state <= S_ELIM_W;
                end
                // wait here until the previous result leaves the output register
                S_ELIM_W: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out.result_value <= r_rdata;
                        r_out.status       <= ST_OK;
                        r_pos              <= r_pos + AW'(1);
                        r_scan             <= r_idx + CW'(1);
                        r_state            <= S_DEL_RD;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        if (r_elim) begin
                            // next count from the entry that followed, wrapped
                            r_acc   <= 9'(r_idx) + 9'(r_step) - 9'd1;
                            r_state <= S_MOD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // the fill count never exceeds the capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // a held result is not overwritten while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("result changed under stall");

    // no item is accepted while a search or shift is running
    a_busy_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_in.ready)
        else $error("ready while busy");
`endif
endmodule
